[hw/rtl/bodm_pkg.sv]
// Shared types and constants for the brake onset deceleration metrics block.
// No dependencies; imported by every module of the block.
package bodm_pkg;

  localparam int ACC_W    = 16;
  localparam int SPD_W    = 16;
  localparam int FORCE_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int PROD_W   = SPD_W + PERIOD_W;
  localparam int DIST_W   = 52;
  localparam int ASUM_W   = 37;
  localparam int CNT_W    = 21;
  localparam int RUN_W    = 12;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 2;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int DIV_STEPS = ASUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};
  localparam logic [RUN_W-1:0]  SSE_NONE = {RUN_W{1'b1}};

  localparam logic [FORCE_W-1:0]  THRESH_RST  = 16'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd655;
  localparam logic [RUN_W-1:0]    CONFIRM_RST = 12'd300;

  localparam logic [IDX_W-1:0] REG_THRESH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CONFIRM = 2'd2;

  typedef struct packed {
    logic                     status;
    logic                     found;
    logic [SPD_W-1:0]         speed;
    logic signed [ASUM_W-1:0] asum;
    logic [CNT_W-1:0]         cnt;
    logic [DIST_W-1:0]        total;
    logic [DIST_W-1:0]        start;
  } rec_t;

endpackage

[hw/rtl/bodm_front.sv]
// Front end: accepts samples, tracks the braking run and accumulates sums.
// Pushes one record summary per last sample. Depends on bodm_pkg.
module bodm_front
  import bodm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ACC_W-1:0]   in_acceleration,
  input  logic [SPD_W-1:0]          in_speed,
  input  logic [FORCE_W-1:0]        in_pedal_force,
  input  logic                      in_last_sample,
  input  logic [FORCE_W-1:0]        threshold,
  input  logic [PERIOD_W-1:0]       period,
  input  logic [RUN_W-1:0]          confirm_len,
  input  logic                      q_full,
  output logic                      q_push,
  output rec_t                      q_rec
);

  logic                     a_valid_r;
  logic signed [ACC_W-1:0]  a_acc_r;
  logic [SPD_W-1:0]         a_spd_r;
  logic                     a_gt_r;
  logic                     a_last_r;
  logic [PROD_W-1:0]        a_prod_r;

  logic [DIST_W-1:0]        total_r, total_nxt;
  logic [DIST_W-1:0]        start_r, start_nxt;
  logic [SPD_W-1:0]         rss_r, rss_nxt;
  logic [SPD_W-1:0]         prev_r, prev_nxt;
  logic [RUN_W-1:0]         run_r, run_nxt;
  logic                     conf_r, conf_nxt;
  logic signed [ASUM_W-1:0] asum_r, asum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [RUN_W-1:0]         sse_r, sse_nxt;

  logic                     hold_a;
  logic                     accept;
  logic                     exec;
  logic [RUN_W-1:0]         need;
  logic [DIST_W:0]          dist_sum;
  logic signed [ASUM_W-1:0] acc_ext;
  logic                     add_ok;
  logic                     rec_status;

  assign hold_a   = a_valid_r & a_last_r & q_full;
  assign in_stall = hold_a;
  assign accept   = in_valid & ~hold_a;
  assign exec     = a_valid_r & ~hold_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!hold_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_acc_r  <= in_acceleration;
      a_spd_r  <= in_speed;
      a_gt_r   <= in_pedal_force > threshold;
      a_last_r <= in_last_sample;
      a_prod_r <= PROD_W'(in_speed) * PROD_W'(period);
    end
  end

  assign need     = (confirm_len == '0) ? RUN_W'(1) : confirm_len;
  assign dist_sum = {1'b0, total_r} + (DIST_W + 1)'(a_prod_r);
  assign acc_ext  = ASUM_W'(a_acc_r);
  assign add_ok   = cnt_r != CNT_MAX;

  always_comb begin
    total_nxt = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
    start_nxt = start_r;
    rss_nxt   = rss_r;
    run_nxt   = run_r;
    conf_nxt  = conf_r;
    asum_nxt  = asum_r;
    cnt_nxt   = cnt_r;
    sse_nxt   = sse_r;
    prev_nxt  = a_spd_r;
    if (conf_r) begin
      if (add_ok) begin
        asum_nxt = asum_r + acc_ext;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end else if (a_gt_r) begin
      if (run_r == '0) begin
        start_nxt = total_r;
        rss_nxt   = prev_r;
        asum_nxt  = acc_ext;
        cnt_nxt   = CNT_W'(1);
        run_nxt   = RUN_W'(1);
      end else begin
        if (add_ok) begin
          asum_nxt = asum_r + acc_ext;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        if (run_r != RUN_MAX) begin
          run_nxt = run_r + RUN_W'(1);
        end
      end
      sse_nxt = '0;
      if (run_nxt >= need) begin
        conf_nxt = 1'b1;
      end
    end else begin
      run_nxt = '0;
      if (sse_r != SSE_NONE) begin
        sse_nxt = sse_r + RUN_W'(1);
      end
    end
  end

  assign rec_status = ~conf_nxt & (sse_nxt < (need - RUN_W'(1)));

  always_comb begin
    q_rec.status = rec_status;
    q_rec.found  = conf_nxt;
    q_rec.speed  = conf_nxt ? rss_nxt : (rec_status ? '0 : a_spd_r);
    q_rec.asum   = asum_nxt;
    q_rec.cnt    = cnt_nxt;
    q_rec.total  = total_nxt;
    q_rec.start  = start_nxt;
  end

  assign q_push = exec & a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (exec && a_last_r)) begin
      total_r <= '0;
      start_r <= '0;
      rss_r   <= '0;
      prev_r  <= '0;
      run_r   <= '0;
      conf_r  <= 1'b0;
      asum_r  <= '0;
      cnt_r   <= '0;
      sse_r   <= SSE_NONE;
    end else if (exec) begin
      total_r <= total_nxt;
      start_r <= start_nxt;
      rss_r   <= rss_nxt;
      prev_r  <= prev_nxt;
      run_r   <= run_nxt;
      conf_r  <= conf_nxt;
      asum_r  <= asum_nxt;
      cnt_r   <= cnt_nxt;
      sse_r   <= sse_nxt;
    end
  end

endmodule

[hw/rtl/bodm_queue.sv]
// Short queue of record summaries between the front end and the back end.
// Depends on bodm_pkg for the summary type.
module bodm_queue
  import bodm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output rec_t head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  rec_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_QW-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = count_r == CNT_FULL;
  assign head_valid = count_r != '0;
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

endmodule

[hw/rtl/bodm_back.sv]
// Back end: takes record summaries, divides the acceleration sum by the count
// one quotient bit per cycle and holds the result item. Depends on bodm_pkg.
module bodm_back
  import bodm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  rec_t                     q_rec,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0] out_mean_decel,
  output logic [SPD_W-1:0]         out_initial_speed,
  output logic [DIST_W-1:0]        out_brake_distance,
  output logic                     out_brake_found,
  output logic                     out_status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      rem_r;
  logic [ASUM_W-1:0]     dvd_r;
  logic [CNT_W-1:0]      dsr_r;
  logic                  neg_r;
  logic [DIV_CNT_W-1:0]  step_r;
  logic                  found_r;
  logic                  status_r;
  logic [SPD_W-1:0]      speed_r;
  logic [DIST_W-1:0]     dist_r;
  logic                  out_valid_r;

  logic [CNT_W:0]        rem_sh;
  logic                  ge;
  logic [CNT_W:0]        rem_diff;
  logic [ASUM_W-1:0]     q_signed;
  logic                  out_free;
  logic                  load_out;

  assign rem_sh   = {rem_r, dvd_r[ASUM_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};
  assign q_signed = neg_r ? (~dvd_r + ASUM_W'(1)) : dvd_r;
  assign out_free = ~out_valid_r | ~out_stall;
  assign load_out = (state_r == ST_DONE) & out_free;
  assign q_pop    = (state_r == ST_IDLE) & q_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_DIV;
      ST_DIV:  if (step_r == STEP_LAST) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dsr_r    <= q_rec.cnt;
      neg_r    <= q_rec.asum[ASUM_W-1];
      dvd_r    <= q_rec.asum[ASUM_W-1] ? (~q_rec.asum + ASUM_W'(1)) : q_rec.asum;
      rem_r    <= '0;
      step_r   <= '0;
      found_r  <= q_rec.found;
      status_r <= q_rec.status;
      speed_r  <= q_rec.speed;
      dist_r   <= q_rec.found ? (q_rec.total - q_rec.start) : '0;
    end else if (state_r == ST_DIV) begin
      rem_r  <= ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_r  <= {dvd_r[ASUM_W-2:0], ge};
      step_r <= step_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_decel     <= (found_r && dsr_r != '0) ? q_signed[ACC_W-1:0] : '0;
      out_initial_speed  <= speed_r;
      out_brake_distance <= dist_r;
      out_brake_found    <= found_r;
      out_status         <= status_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/brake_onset_decel_metrics_unit.sv]
// Brake onset deceleration metrics: one sample per cycle in while in_stall is low,
// one result per record. A record's last sample passes the input stage register,
// the queue, the 37-step restoring divider in the back end and output registers.
// in_stall rises while a last sample waits on a full queue; the back end takes
// one record at a time; a queue of QUEUE_DEPTH summaries absorbs short records.
// Reset: synchronous rst_n loads register defaults and clears all record state.
module brake_onset_decel_metrics_unit
  import bodm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ACC_W-1:0]  in_acceleration,
  input  logic [SPD_W-1:0]         in_speed,
  input  logic [FORCE_W-1:0]       in_pedal_force,
  input  logic                     in_last_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  out_mean_decel,
  output logic [SPD_W-1:0]         out_initial_speed,
  output logic [DIST_W-1:0]        out_brake_distance,
  output logic                     out_brake_found,
  output logic                     out_status,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic [FORCE_W-1:0]  thresh_r;
  logic [PERIOD_W-1:0] period_r;
  logic [RUN_W-1:0]    confirm_r;
  logic [IDX_W-1:0]    reg_idx;
  logic                wr_en;

  logic q_full;
  logic q_push;
  rec_t q_push_rec;
  logic q_pop;
  logic q_valid;
  rec_t q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      period_r  <= PERIOD_RST;
      confirm_r <= CONFIRM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESH:  thresh_r  <= pwdata[FORCE_W-1:0];
        REG_PERIOD:  period_r  <= pwdata[PERIOD_W-1:0];
        REG_CONFIRM: confirm_r <= pwdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESH:  prdata = DATA_W'(thresh_r);
      REG_PERIOD:  prdata = DATA_W'(period_r);
      REG_CONFIRM: prdata = DATA_W'(confirm_r);
      default:     prdata = '0;
    endcase
  end

  bodm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_acceleration (in_acceleration),
    .in_speed        (in_speed),
    .in_pedal_force  (in_pedal_force),
    .in_last_sample  (in_last_sample),
    .threshold       (thresh_r),
    .period          (period_r),
    .confirm_len     (confirm_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_rec           (q_push_rec)
  );

  bodm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (q_head)
  );

  bodm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rec              (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mean_decel     (out_mean_decel),
    .out_initial_speed  (out_initial_speed),
    .out_brake_distance (out_brake_distance),
    .out_brake_found    (out_brake_found),
    .out_status         (out_status)
  );

endmodule

[hw/rtl/bodm_checker.sv]
// Port-level checks for brake_onset_decel_metrics_unit, bound to the top level.
// Depends on bodm_pkg for field widths.
module bodm_checker
  import bodm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ACC_W-1:0]  out_mean_decel,
  input logic [SPD_W-1:0]         out_initial_speed,
  input logic [DIST_W-1:0]        out_brake_distance,
  input logic                     out_brake_found,
  input logic                     out_status,
  input logic                     pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_decel)
      && $stable(out_brake_distance) && $stable(out_status))
    else $error("stalled result item changed");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_brake_found && out_mean_decel == '0
      && out_initial_speed == '0 && out_brake_distance == '0)
    else $error("error status with nonzero metrics");

  a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_brake_found |-> out_mean_decel == '0 && out_brake_distance == '0)
    else $error("metrics without braking onset");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("result item right after reset");

endmodule

bind brake_onset_decel_metrics_unit bodm_checker u_bodm_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for brake_onset_decel_metrics_unit: streams braking records,
// predicts each record's metrics in a scoreboard class and compares every result item.
// Depends on bodm_pkg and the block's RTL only.
module testbench;
  import bodm_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [ACC_W-1:0] mean;
    logic [SPD_W-1:0]        speed;
    logic [DIST_W-1:0]       distance;
    logic                    found;
    logic                    status;
  } metrics_t;

  class brake_metrics_scoreboard;
    logic [FORCE_W-1:0]  thresh;
    logic [PERIOD_W-1:0] period;
    logic [RUN_W-1:0]    confirm;
    logic [DIST_W-1:0]   total_dist;
    logic [DIST_W-1:0]   onset_dist;
    logic [SPD_W-1:0]    onset_speed;
    logic [SPD_W-1:0]    prev_speed;
    logic [RUN_W-1:0]    run_len;
    logic [RUN_W-1:0]    since_exceed;
    bit                  confirmed;
    longint              accel_total;
    int unsigned         accel_count;
    metrics_t            expected_q[$];
    int                  errors;

    function new();
      thresh  = THRESH_RST;
      period  = PERIOD_RST;
      confirm = CONFIRM_RST;
      errors  = 0;
      clear_record();
    endfunction

    function void clear_record();
      total_dist   = '0;
      onset_dist   = '0;
      onset_speed  = '0;
      prev_speed   = '0;
      run_len      = '0;
      confirmed    = 1'b0;
      accel_total  = 0;
      accel_count  = 0;
      since_exceed = SSE_NONE;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_THRESH:  thresh  = value[FORCE_W-1:0];
        REG_PERIOD:  period  = value[PERIOD_W-1:0];
        REG_CONFIRM: confirm = value[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned need_len();
      return (confirm == 0) ? 1 : confirm;
    endfunction

    function void add_accel(logic signed [ACC_W-1:0] acc);
      if (accel_count < CNT_MAX) begin
        accel_total += acc;
        accel_count++;
      end
    endfunction

    function void note_sample(logic signed [ACC_W-1:0] acc, logic [SPD_W-1:0] spd,
                              logic [FORCE_W-1:0] frc, logic last);
      logic [DIST_W-1:0] prior;
      logic [63:0]       sum;
      int unsigned       need;
      longint            mean;
      metrics_t          m;
      need  = need_len();
      prior = total_dist;
      sum   = 64'(prior) + 64'(spd) * 64'(period);
      total_dist = (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
      if (confirmed) begin
        add_accel(acc);
      end else if (frc > thresh) begin
        if (run_len == 0) begin
          onset_dist  = prior;
          onset_speed = prev_speed;
          accel_total = acc;
          accel_count = 1;
          run_len     = 1;
        end else begin
          add_accel(acc);
          if (run_len != RUN_MAX) run_len++;
        end
        since_exceed = '0;
        if (run_len >= need) confirmed = 1'b1;
      end else begin
        run_len = '0;
        if (since_exceed != SSE_NONE) since_exceed++;
      end
      prev_speed = spd;
      if (!last) return;
      if (!confirmed && since_exceed < need - 1) begin
        m = '{mean: '0, speed: '0, distance: '0, found: 1'b0, status: 1'b1};
      end else if (confirmed) begin
        mean = accel_total / longint'(accel_count);
        m = '{mean: mean[ACC_W-1:0], speed: onset_speed, distance: total_dist - onset_dist,
              found: 1'b1, status: 1'b0};
      end else begin
        m = '{mean: '0, speed: spd, distance: '0, found: 1'b0, status: 1'b0};
      end
      expected_q = {expected_q, m};
      clear_record();
    endfunction

    function void check_result(metrics_t got);
      metrics_t exp_m;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: mean %0d speed %0d dist %0d found %0b status %0b",
                   got.mean, got.speed, got.distance, got.found, got.status);
        return;
      end
      exp_m = expected_q.pop_front();
      if (got.mean !== exp_m.mean || got.speed !== exp_m.speed ||
          got.distance !== exp_m.distance ||
          got.found !== exp_m.found || got.status !== exp_m.status) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch, exp: mean %0d speed %0d dist %0d found %0b status %0b",
                   exp_m.mean, exp_m.speed, exp_m.distance, exp_m.found, exp_m.status);
          $display("                 got: mean %0d speed %0d dist %0d found %0b status %0b",
                   got.mean, got.speed, got.distance, got.found, got.status);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [ACC_W-1:0] in_acceleration;
  logic [SPD_W-1:0]        in_speed;
  logic [FORCE_W-1:0]      in_pedal_force;
  logic                    in_last_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [ACC_W-1:0] out_mean_decel;
  logic [SPD_W-1:0]        out_initial_speed;
  logic [DIST_W-1:0]       out_brake_distance;
  logic                    out_brake_found;
  logic                    out_status;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  brake_metrics_scoreboard sb;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  brake_onset_decel_metrics_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_acceleration, .in_speed, .in_pedal_force, .in_last_sample,
    .out_valid, .out_stall, .out_mean_decel, .out_initial_speed, .out_brake_distance,
    .out_brake_found, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    metrics_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{mean: out_mean_decel, speed: out_initial_speed, distance: out_brake_distance,
              found: out_brake_found, status: out_status};
      sb.check_result(got);
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [ACC_W-1:0] acc, logic [SPD_W-1:0] spd,
                             logic [FORCE_W-1:0] frc, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_acceleration <= acc;
    in_speed        <= spd;
    in_pedal_force  <= frc;
    in_last_sample  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(acc, spd, frc, last);
  endtask

  function automatic logic [FORCE_W-1:0] pick_above(logic [FORCE_W-1:0] thr);
    if (thr == '1) return '1;
    return FORCE_W'($urandom_range(65535, int'(thr) + 1));
  endfunction

  function automatic logic [FORCE_W-1:0] pick_below(logic [FORCE_W-1:0] thr);
    return FORCE_W'($urandom_range(int'(thr), 0));
  endfunction

  // kind 0: quiet lead-in, confirmed run, random tail
  // kind 1: exceedance shorter than the confirmation length, then a random tail
  // kind 2: random force pattern
  task automatic send_record(int kind, output int count);
    int unsigned need;
    int lead, run, tail;
    logic [FORCE_W-1:0] frc;
    need = sb.need_len();
    case (kind)
      0: begin
        lead = $urandom_range(0, 4);
        run  = need + $urandom_range(0, 3);
        tail = $urandom_range(0, 6);
      end
      1: begin
        lead = $urandom_range(0, 6);
        run  = (need > 1) ? $urandom_range(1, need - 1) : 0;
        tail = $urandom_range(0, 3);
      end
      default: begin
        lead = 0;
        run  = 0;
        tail = $urandom_range(1, 12);
      end
    endcase
    count = lead + run + tail;
    if (count == 0) begin
      tail  = 1;
      count = 1;
    end
    for (int i = 0; i < count; i++) begin
      if (i < lead) frc = pick_below(sb.thresh);
      else if (i < lead + run) frc = pick_above(sb.thresh);
      else frc = $urandom_range(0, 1) ? pick_above(sb.thresh) : pick_below(sb.thresh);
      send_sample(ACC_W'($urandom), SPD_W'($urandom), frc, i == count - 1);
    end
  endtask

  task automatic settle_and_program(logic [FORCE_W-1:0] thr, logic [PERIOD_W-1:0] per,
                                    logic [RUN_W-1:0] conf);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(REG_THRESH, {16'($urandom), thr});
    reg_write(REG_PERIOD, {16'($urandom), per});
    reg_write(REG_CONFIRM, {20'($urandom), conf});
    if ($urandom_range(0, 1)) reg_write(REG_UNUSED, $urandom);
  endtask

  task automatic run_phase(logic [FORCE_W-1:0] thr, logic [PERIOD_W-1:0] per,
                           logic [RUN_W-1:0] conf, int quota, int kind_fix, bit pressure);
    int sent;
    int n;
    int kind;
    settle_and_program(thr, per, conf);
    if (pressure) hold_req = 1'b1;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 9);
      kind = (kind_fix >= 0) ? kind_fix : (kind < 6) ? 0 : (kind < 8) ? 1 : 2;
      send_record(kind, n);
      sent += n;
    end
  endtask

  initial begin
    sb = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_acceleration = '0;
    in_speed        = '0;
    in_pedal_force  = '0;
    in_last_sample  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(16'sd5, 16'd100, 16'd7, 1'b1);

    settle_and_program(16'd1000, 16'hFFFF, 12'd2);
    send_sample(-16'sd32768, 16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'sd32767, 16'd0, 16'hFFFF, 1'b1);
    send_sample(16'sd0, 16'hFFFF, 16'd0, 1'b1);
    send_sample(16'sd1, 16'd2, 16'd1000, 1'b0);
    send_sample(-16'sd1, 16'd3, 16'd1001, 1'b1);
    send_sample(16'sd100, 16'd11, 16'd0, 1'b0);
    send_sample(-16'sd200, 16'd22, 16'd2000, 1'b0);
    send_sample(-16'sd301, 16'd33, 16'hFFFF, 1'b1);
    send_sample(16'sd7, 16'd5, 16'd5000, 1'b0);
    send_sample(16'sd8, 16'd6, 16'd0, 1'b0);
    send_sample(-16'sd9, 16'd7, 16'd3000, 1'b0);
    send_sample(-16'sd10, 16'd8, 16'd3000, 1'b0);
    send_sample(16'sd11, 16'd9, 16'd0, 1'b0);
    send_sample(16'sd12, 16'd10, 16'd0, 1'b1);
    send_sample(16'sd1, 16'd1, 16'd2000, 1'b0);
    send_sample(16'sd2, 16'd2, 16'd0, 1'b0);
    send_sample(16'sd3, 16'd3, 16'd999, 1'b1);

    run_phase(16'd0, 16'hFFFF, 12'd0, 250, -1, 1'b0);
    run_phase(16'hFFFF, 16'd0, 12'd1, 150, -1, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 12'd5, 300, -1, 1'b1);
    run_phase(16'd32768, 16'hFFFF, 12'd17, 300, -1, 1'b0);
    run_phase(16'($urandom_range(0, 255)), 16'($urandom), 12'd40, 250, -1, 1'b0);
    run_phase(16'($urandom_range(0, 1023)), 16'd1, 12'd4095, 40, 2, 1'b0);
    settle_and_program(16'd0, 16'd0, 12'd0);
    idle_on = 1'b0;
    run_phase(16'($urandom), 16'($urandom), 12'd3, 550, -1, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/bodm_pkg.sv
hw/rtl/bodm_front.sv
hw/rtl/bodm_queue.sv
hw/rtl/bodm_back.sv
hw/rtl/brake_onset_decel_metrics_unit.sv
hw/rtl/bodm_checker.sv
tb/testbench.sv
